@@ design/lpcm_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lpcm_pkg: shared types, constants and functions of the compositor
// Opcodes, register indexes, the stage record that passes from the layer
// select stage to the blend stage, and the RGB555 color math helpers.
// ============================================================================
package lpcm_pkg;

  // Palette geometry.
  localparam int PaletteEntries = 256;
  localparam int PAL_AW         = $clog2(PaletteEntries);

  // Layer layout: bg1..bg4 and sprites; the backdrop is the code past them.
  localparam int PriorityBitsDefault = 4;
  localparam int LAYERS              = 5;
  localparam int PAL_IDX_W           = 8;
  localparam logic [2:0] LAYER_BG1      = 3'd0;
  localparam logic [2:0] LAYER_SPRITE   = 3'd4;
  localparam logic [2:0] LAYER_BACKDROP = 3'd5;

  // Pixel and port widths.
  localparam int COLOR_W    = 15;
  localparam int BRIGHT_W   = 4;
  localparam int PIXEL_W    = COLOR_W + BRIGHT_W;
  localparam int OUT_W      = ((2 * PIXEL_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int LINE_W     = 9;
  localparam int TILE_W     = 16;

  // Register bit positions.
  localparam int MC_SUB_OPERAND  = 0;
  localparam int MC_DIRECT       = 1;
  localparam int MC_SUBTRACT     = 2;
  localparam int MC_HALVE        = 3;
  localparam int DC_PSEUDO_HIRES = 0;
  localparam int DC_DISPLAY_OFF  = 1;
  localparam int DC_OVERSCAN     = 2;
  localparam int WIN_MAIN        = 0;
  localparam int WIN_SUB         = 1;

  // Thresholds.
  localparam logic [PAL_IDX_W-1:0] SPRITE_MATH_MIN = 8'd192;
  localparam logic [LINE_W-1:0]    BLANK_LINE      = 9'd225;

  // Background modes with a special meaning.
  localparam logic [2:0] MODE_3 = 3'd3;
  localparam logic [2:0] MODE_4 = 3'd4;
  localparam logic [2:0] MODE_5 = 3'd5;
  localparam logic [2:0] MODE_6 = 3'd6;
  localparam logic [2:0] MODE_7 = 3'd7;

  // Color math masks, widened to the working width of the math.
  localparam logic [16:0] MASK_LSB   = 17'h00421;
  localparam logic [16:0] MASK_MSB   = 17'h08420;
  localparam logic [16:0] MASK_HALVE = 17'h07bde;

  // Opcodes carried in tuser.
  typedef enum logic [1:0] {
    OP_LINE    = 2'd0,
    OP_PIXEL   = 2'd1,
    OP_PALETTE = 2'd2
  } lpcm_op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MATH_CONTROL  = 3'd0,
    REG_LAYER_MATH    = 3'd1,
    REG_MATH_COLOR    = 3'd2,
    REG_BG_MODE       = 3'd3,
    REG_DISPLAY_CTRL  = 3'd4,
    REG_BRIGHTNESS    = 3'd5,
    REG_WINDOW_MASK   = 3'd6
  } lpcm_reg_e;

  // What the blend stage does with a beat.
  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_BLANK = 2'd2
  } lpcm_kind_e;

  // Configuration register file.
  typedef struct packed {
    logic [3:0]         math_control;
    logic [5:0]         layer_math_enable;
    logic [COLOR_W-1:0] math_color;
    logic [2:0]         bg_mode;
    logic [2:0]         display_control;
    logic [BRIGHT_W-1:0] brightness;
    logic [1:0]         window_line_mask;
  } lpcm_cfg_t;

  // Record handed from the select stage to the blend stage.
  typedef struct packed {
    logic               valid;
    lpcm_kind_e         kind;
    logic               main_direct;
    logic [COLOR_W-1:0] main_direct_color;
    logic               main_sub_math;
    logic               main_window;
    logic               sub_direct;
    logic [COLOR_W-1:0] sub_direct_color;
    logic               sub_transparent;
  } lpcm_stage_t;

  // Direct color from a bg1 palette index and its tile word.
  function automatic logic [COLOR_W-1:0] direct_rgb(input logic [PAL_IDX_W-1:0] p,
                                                    input logic [TILE_W-1:0] t);
    return {p[7:6], t[12], 2'b00, p[5:3], t[11], 1'b0, p[2:0], t[10], 1'b0};
  endfunction

  // Saturating RGB555 add or subtract, optionally halved.
  function automatic logic [COLOR_W-1:0] color_math(input logic [COLOR_W-1:0] x,
                                                    input logic [COLOR_W-1:0] y,
                                                    input logic sub_op,
                                                    input logic halve);
    logic [16:0] xx, yy, xy, sum, diff, carry, borrow, res;
    xx     = {2'b00, x};
    yy     = {2'b00, y};
    xy     = xx ^ yy;
    sum    = xx + yy;
    diff   = xx - yy + MASK_MSB;
    carry  = (sum - (xy & MASK_LSB)) & MASK_MSB;
    borrow = (diff - (xy & MASK_MSB)) & MASK_MSB;
    if (!sub_op) begin
      if (!halve) begin
        res = (sum - carry) | (carry - (carry >> 5));
      end else begin
        res = (sum - (xy & MASK_LSB)) >> 1;
      end
    end else begin
      res = (diff - borrow) & (borrow - (borrow >> 5));
      if (halve) begin
        res = (res & MASK_HALVE) >> 1;
      end
    end
    return res[COLOR_W-1:0];
  endfunction

endpackage

@@ design/lpcm_palette.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lpcm_palette: 256-entry RGB555 palette memory
// One write port and two registered read ports, one for the main screen
// winner and one for the sub screen winner. Read data holds while disabled.
// ============================================================================
module lpcm_palette import lpcm_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [PAL_AW-1:0]  waddr_i,
  input  logic [COLOR_W-1:0] wdata_i,
  input  logic               re_i,
  input  logic [PAL_AW-1:0]  raddr_main_i,
  input  logic [PAL_AW-1:0]  raddr_sub_i,
  output logic [COLOR_W-1:0] rdata_main_o,
  output logic [COLOR_W-1:0] rdata_sub_o
);

  logic [COLOR_W-1:0] mem [PaletteEntries];
  logic [COLOR_W-1:0] rdata_main_q, rdata_sub_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two read ports with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_main_q <= mem[raddr_main_i];
      rdata_sub_q  <= mem[raddr_sub_i];
    end
  end

  assign rdata_main_o = rdata_main_q;
  assign rdata_sub_o  = rdata_sub_q;

endmodule

@@ design/lpcm_select.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lpcm_select: layer priority select stage
// Picks the winning layer of each screen, forms the palette read addresses
// and the direct colors, and registers the stage record for the blend stage.
// ============================================================================
module lpcm_select import lpcm_pkg::*; #(
  parameter int PriorityBits = PriorityBitsDefault,
  localparam int PriW = LAYERS * PriorityBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  logic                         accept_i,
  input  logic [1:0]                   opcode_i,
  input  logic [LINE_W-1:0]            line_i,
  input  logic [PriW-1:0]              main_priorities_i,
  input  logic [LAYERS*PAL_IDX_W-1:0]  main_palettes_i,
  input  logic [PriW-1:0]              sub_priorities_i,
  input  logic [LAYERS*PAL_IDX_W-1:0]  sub_palettes_i,
  input  logic [TILE_W-1:0]            main_tile_i,
  input  logic [TILE_W-1:0]            sub_tile_i,
  input  logic [1:0]                   window_flags_i,
  input  lpcm_cfg_t                    cfg_i,
  output logic [PAL_AW-1:0]            raddr_main_o,
  output logic [PAL_AW-1:0]            raddr_sub_o,
  output lpcm_stage_t                  stage_o
);

  // Highest nonzero priority wins; ties go to the earlier layer.
  function automatic logic [2:0] pick(input logic [PriW-1:0] pri);
    logic [PriorityBits-1:0] best;
    logic [2:0]              win;
    best = '0;
    win  = LAYER_BACKDROP;
    for (int k = 0; k < LAYERS; k++) begin
      if (pri[k*PriorityBits +: PriorityBits] > best) begin
        best = pri[k*PriorityBits +: PriorityBits];
        win  = 3'(k);
      end
    end
    return win;
  endfunction

  // Palette index of the winner; the backdrop is entry zero.
  function automatic logic [PAL_IDX_W-1:0] index_of(input logic [LAYERS*PAL_IDX_W-1:0] pal,
                                                    input logic [2:0] win);
    logic [PAL_IDX_W-1:0] idx;
    idx = '0;
    for (int k = 0; k < LAYERS; k++) begin
      if (win == 3'(k)) begin
        idx = pal[k*PAL_IDX_W +: PAL_IDX_W];
      end
    end
    return idx;
  endfunction

  logic [2:0]           main_win, sub_win;
  logic [PAL_IDX_W-1:0] main_idx, sub_idx;
  logic                 direct_on, blank, main_sub_math;
  lpcm_stage_t          stage_d, stage_q;

  assign main_win  = pick(main_priorities_i);
  assign sub_win   = pick(sub_priorities_i);
  assign main_idx  = index_of(main_palettes_i, main_win);
  assign sub_idx   = index_of(sub_palettes_i, sub_win);
  assign direct_on = cfg_i.math_control[MC_DIRECT] &&
                     (cfg_i.bg_mode == MODE_3 || cfg_i.bg_mode == MODE_4 ||
                      cfg_i.bg_mode == MODE_7);
  assign blank     = cfg_i.display_control[DC_DISPLAY_OFF] ||
                     (!cfg_i.display_control[DC_OVERSCAN] && line_i >= BLANK_LINE);

  // Line start reads the backdrop entry on the main port.
  assign raddr_main_o = (opcode_i == OP_LINE) ? '0 : PAL_AW'(main_idx);
  assign raddr_sub_o  = PAL_AW'(sub_idx);

  // Color math enable of the main screen winner.
  always_comb begin
    if (main_win == LAYER_BACKDROP) begin
      main_sub_math = cfg_i.layer_math_enable[LAYER_BACKDROP];
    end else if (main_win == LAYER_SPRITE) begin
      main_sub_math = cfg_i.layer_math_enable[LAYER_SPRITE] && (main_idx >= SPRITE_MATH_MIN);
    end else begin
      main_sub_math = cfg_i.layer_math_enable[main_win];
    end
  end

  // Stage record.
  always_comb begin
    stage_d.valid = accept_i &&
                    (opcode_i == OP_LINE || (opcode_i == OP_PIXEL && line_i != '0));
    if (opcode_i == OP_LINE) begin
      stage_d.kind = KIND_LINE;
    end else if (blank) begin
      stage_d.kind = KIND_BLANK;
    end else begin
      stage_d.kind = KIND_PIXEL;
    end
    stage_d.main_direct       = direct_on && (main_win == LAYER_BG1);
    stage_d.main_direct_color = direct_rgb(main_idx, main_tile_i);
    stage_d.main_sub_math     = main_sub_math && window_flags_i[WIN_SUB];
    stage_d.main_window       = window_flags_i[WIN_MAIN];
    stage_d.sub_direct        = direct_on && (sub_win == LAYER_BG1);
    stage_d.sub_direct_color  = direct_rgb(sub_idx, sub_tile_i);
    stage_d.sub_transparent   = (sub_win == LAYER_BACKDROP);
  end

  // The stage moves together with the palette read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (adv_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

@@ design/lpcm_blend.sv @@
`timescale 1ns / 1ps
// ============================================================================
// lpcm_blend: color math stage and output register
// Holds the per-line math state, resolves both screen colors from the
// palette data, applies color math and registers the output beat.
// ============================================================================
module lpcm_blend import lpcm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  lpcm_stage_t        stage_i,
  input  logic [COLOR_W-1:0] rdata_main_i,
  input  logic [COLOR_W-1:0] rdata_sub_i,
  input  lpcm_cfg_t          cfg_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [PIXEL_W-1:0] first_pixel_o,
  output logic [PIXEL_W-1:0] second_pixel_o
);

  logic [COLOR_W-1:0] main_color_q, main_color_d, sub_color_q, sub_color_d;
  logic               main_math_q, main_math_d, sub_math_q, sub_math_d;
  logic               sub_trans_q, sub_trans_d, use_sub_q, use_sub_d;
  logic               halve_q, halve_d;
  logic               out_valid_q, load;
  logic [PIXEL_W-1:0] first_q, first_d, second_q, second_d;
  logic [COLOR_W-1:0] s_res, m_res;
  logic               hires, fire;

  assign fire  = adv_i && stage_i.valid;
  assign hires = cfg_i.display_control[DC_PSEUDO_HIRES] ||
                 cfg_i.bg_mode == MODE_5 || cfg_i.bg_mode == MODE_6;

  // Screen resolution and color math.
  always_comb begin
    main_color_d = main_color_q;
    sub_color_d  = sub_color_q;
    main_math_d  = main_math_q;
    sub_math_d   = sub_math_q;
    sub_trans_d  = sub_trans_q;
    use_sub_d    = use_sub_q;
    halve_d      = halve_q;
    s_res        = '0;
    m_res        = '0;
    load         = 1'b0;
    if (fire) begin
      unique case (stage_i.kind)
        KIND_LINE: begin
          main_color_d = rdata_main_i;
          sub_color_d  = rdata_main_i;
          main_math_d  = !cfg_i.window_line_mask[WIN_MAIN];
          sub_math_d   = !cfg_i.window_line_mask[WIN_SUB] &&
                         cfg_i.layer_math_enable[LAYER_BACKDROP];
          sub_trans_d  = 1'b1;
          use_sub_d    = 1'b0;
          halve_d      = cfg_i.math_control[MC_HALVE] &&
                         !cfg_i.math_control[MC_SUB_OPERAND] &&
                         !cfg_i.window_line_mask[WIN_MAIN];
        end
        KIND_BLANK: begin
          load = 1'b1;
        end
        KIND_PIXEL: begin
          load = 1'b1;
          // Sub screen first, against the math state left by the last pixel or line start.
          sub_color_d = stage_i.sub_direct ? stage_i.sub_direct_color : rdata_sub_i;
          sub_trans_d = stage_i.sub_transparent;
          if (!sub_math_q) begin
            s_res = main_math_q ? sub_color_d : '0;
          end else begin
            s_res = color_math(main_math_q ? sub_color_d : '0,
                               use_sub_q ? main_color_q : cfg_i.math_color,
                               cfg_i.math_control[MC_SUBTRACT], halve_q);
          end
          // Main screen next.
          main_color_d = stage_i.main_direct ? stage_i.main_direct_color : rdata_main_i;
          sub_math_d   = stage_i.main_sub_math;
          main_math_d  = stage_i.main_window;
          if (!sub_math_d) begin
            m_res = main_math_d ? main_color_d : '0;
          end else begin
            if (cfg_i.math_control[MC_SUB_OPERAND] && sub_trans_d) begin
              use_sub_d = 1'b0;
              halve_d   = 1'b0;
            end else begin
              use_sub_d = cfg_i.math_control[MC_SUB_OPERAND];
              halve_d   = cfg_i.math_control[MC_HALVE] && main_math_d;
            end
            m_res = color_math(main_math_d ? main_color_d : '0,
                               use_sub_d ? sub_color_d : cfg_i.math_color,
                               cfg_i.math_control[MC_SUBTRACT], halve_d);
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
    first_d  = {cfg_i.brightness, hires ? s_res : m_res};
    second_d = {cfg_i.brightness, m_res};
  end

  // Math state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_color_q <= '0;
      sub_color_q  <= '0;
      main_math_q  <= 1'b0;
      sub_math_q   <= 1'b0;
      sub_trans_q  <= 1'b1;
      use_sub_q    <= 1'b0;
      halve_q      <= 1'b0;
    end else begin
      main_color_q <= main_color_d;
      sub_color_q  <= sub_color_d;
      main_math_q  <= main_math_d;
      sub_math_q   <= sub_math_d;
      sub_trans_q  <= sub_trans_d;
      use_sub_q    <= use_sub_d;
      halve_q      <= halve_d;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_pixel_o  = first_q;
  assign second_pixel_o = second_q;

endmodule

@@ design/layer_priority_color_math.sv @@
`timescale 1ns / 1ps
// ============================================================================
// layer_priority_color_math: main and sub screen compositor with color math
// Pipeline: a pixel beat is registered in the select stage together with its
// palette read when accepted, then the blend stage loads its result into the
// output register, which drives it on m_axis.
// Throughput: one beat per cycle, set by the single pass through the palette
// read ports and the blend stage; stalls only while a result waits untaken.
// Reset clears configuration, control and math state (sub screen marked
// transparent); the palette is not cleared and is undefined until written.
// ============================================================================
module layer_priority_color_math import lpcm_pkg::*; #(
  parameter int PriorityBits = PriorityBitsDefault,
  localparam int PriW      = LAYERS * PriorityBits,
  localparam int PalW      = LAYERS * PAL_IDX_W,
  localparam int LineLo    = 0,
  localparam int MainPriLo = LineLo + LINE_W,
  localparam int MainPalLo = MainPriLo + PriW,
  localparam int SubPriLo  = MainPalLo + PalW,
  localparam int SubPalLo  = SubPriLo + PriW,
  localparam int MainTileLo = SubPalLo + PalW,
  localparam int SubTileLo = MainTileLo + TILE_W,
  localparam int WinLo     = SubTileLo + TILE_W,
  localparam int PalAddrLo = WinLo + 2,
  localparam int PalValLo  = PalAddrLo + PAL_AW,
  localparam int InRaw     = PalValLo + COLOR_W,
  localparam int IN_W      = ((InRaw + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // line, main_priorities, main_palettes, sub_priorities, sub_palettes,
  // main_tile, sub_tile, window_flags, palette_address, palette_value
  input  logic [IN_W-1:0]       s_axis_tdata,
  // opcode
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // first_pixel, second_pixel
  output logic [OUT_W-1:0]      m_axis_tdata
);

  lpcm_cfg_t          cfg_q;
  lpcm_stage_t        stage;
  logic               adv, accept;
  logic [PAL_AW-1:0]  raddr_main, raddr_sub;
  logic [COLOR_W-1:0] rdata_main, rdata_sub;
  logic [PIXEL_W-1:0] first_pixel, second_pixel;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MATH_CONTROL: cfg_q.math_control      <= cfg_data_i[3:0];
        REG_LAYER_MATH:   cfg_q.layer_math_enable <= cfg_data_i[5:0];
        REG_MATH_COLOR:   cfg_q.math_color        <= cfg_data_i[COLOR_W-1:0];
        REG_BG_MODE:      cfg_q.bg_mode           <= cfg_data_i[2:0];
        REG_DISPLAY_CTRL: cfg_q.display_control   <= cfg_data_i[2:0];
        REG_BRIGHTNESS:   cfg_q.brightness        <= cfg_data_i[BRIGHT_W-1:0];
        REG_WINDOW_MASK:  cfg_q.window_line_mask  <= cfg_data_i[1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // The pipeline moves unless a result in the blend stage meets a full,
  // untaken output register.
  assign adv = !stage.valid || stage.kind == KIND_LINE || !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept = s_axis_tvalid && adv;

  lpcm_select #(
    .PriorityBits(PriorityBits)
  ) u_select (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .accept_i          (accept),
    .opcode_i          (s_axis_tuser),
    .line_i            (s_axis_tdata[LineLo +: LINE_W]),
    .main_priorities_i (s_axis_tdata[MainPriLo +: PriW]),
    .main_palettes_i   (s_axis_tdata[MainPalLo +: PalW]),
    .sub_priorities_i  (s_axis_tdata[SubPriLo +: PriW]),
    .sub_palettes_i    (s_axis_tdata[SubPalLo +: PalW]),
    .main_tile_i       (s_axis_tdata[MainTileLo +: TILE_W]),
    .sub_tile_i        (s_axis_tdata[SubTileLo +: TILE_W]),
    .window_flags_i    (s_axis_tdata[WinLo +: 2]),
    .cfg_i             (cfg_q),
    .raddr_main_o      (raddr_main),
    .raddr_sub_o       (raddr_sub),
    .stage_o           (stage)
  );

  lpcm_palette u_palette (
    .clk_i        (clk_i),
    .we_i         (accept && s_axis_tuser == OP_PALETTE),
    .waddr_i      (s_axis_tdata[PalAddrLo +: PAL_AW]),
    .wdata_i      (s_axis_tdata[PalValLo +: COLOR_W]),
    .re_i         (adv),
    .raddr_main_i (raddr_main),
    .raddr_sub_i  (raddr_sub),
    .rdata_main_o (rdata_main),
    .rdata_sub_o  (rdata_sub)
  );

  lpcm_blend u_blend (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .stage_i        (stage),
    .rdata_main_i   (rdata_main),
    .rdata_sub_i    (rdata_sub),
    .cfg_i          (cfg_q),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .first_pixel_o  (first_pixel),
    .second_pixel_o (second_pixel)
  );

  assign m_axis_tdata = {(OUT_W - 2 * PIXEL_W)'(0), second_pixel, first_pixel};

  // Input is held back only by an untaken result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a pending output beat");

  // A palette write never enters the blend stage.
  a_palette_no_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == OP_PALETTE) |=> !stage.valid)
    else $error("palette write reached the blend stage");

  // A new output beat comes only from a pixel in the blend stage.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(stage.valid && stage.kind != KIND_LINE))
    else $error("output beat without a pixel in the blend stage");

endmodule

@@ dv/tb_layer_priority_color_math.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_layer_priority_color_math: self-checking bench for the compositor
// Streams line-start, pixel, palette-write and unused-opcode beats into the
// block under bursty input timing and a patterned output stall. A behavioral
// compositor predicts every pixel pair, and each result beat is compared per
// field. The palette is fully loaded first, then a directed set and a series
// of randomly configured phases run, including the all-zero and all-ones
// register settings.
// ============================================================================
module tb_layer_priority_color_math;
  import lpcm_pkg::*;

  localparam int PRI_W        = LAYERS * PriorityBitsDefault;
  localparam int PAL_W        = LAYERS * PAL_IDX_W;
  localparam int RESET_CYCLES = 10;
  localparam int SETTLE_CYCLES = 6;
  localparam int STUCK_LIMIT  = 5000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_BEATS  = 98;

  // Opcode value that the block has to ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Bit masks that build a direct color from a bg1 index and tile word.
  localparam logic [31:0] DIRECT_B_HI = 32'h6000;
  localparam logic [31:0] DIRECT_B_LO = 32'h1000;
  localparam logic [31:0] DIRECT_G_HI = 32'h0380;
  localparam logic [31:0] DIRECT_G_LO = 32'h0040;
  localparam logic [31:0] DIRECT_R_HI = 32'h001c;
  localparam logic [31:0] DIRECT_R_LO = 32'h0002;

  // Input beat payload; the last member sits in the lowest bits.
  typedef struct packed {
    logic [COLOR_W-1:0]   pal_value;
    logic [PAL_AW-1:0]    pal_addr;
    logic [1:0]           win;
    logic [TILE_W-1:0]    sub_tile;
    logic [TILE_W-1:0]    main_tile;
    logic [PAL_W-1:0]     sub_pal;
    logic [PRI_W-1:0]     sub_pri;
    logic [PAL_W-1:0]     main_pal;
    logic [PRI_W-1:0]     main_pri;
    logic [LINE_W-1:0]    line;
  } beat_fields_t;

  // One output beat: first pixel in the low bits.
  typedef struct packed {
    logic [PIXEL_W-1:0] second;
    logic [PIXEL_W-1:0] first;
  } pixel_pair_t;

  localparam int FIELDS_W = $bits(beat_fields_t);
  localparam int IN_W     = ((FIELDS_W + 7) / 8) * 8;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;

  layer_priority_color_math i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Compositor state mirrored by the predictor.
  lpcm_cfg_t          cfg = '0;
  logic [COLOR_W-1:0] pal_mem [PaletteEntries];
  logic [COLOR_W-1:0] m_col   = '0;
  logic [COLOR_W-1:0] s_col   = '0;
  logic               m_math  = 1'b0;
  logic               s_math  = 1'b0;
  logic               s_clear = 1'b1;
  logic               op_sub  = 1'b0;
  logic               half_on = 1'b0;

  pixel_pair_t pending_pixels [$];

  int error_count     = 0;
  int beats_sent      = 0;
  int pixels_expected = 0;
  int pixels_checked  = 0;
  int config_count    = 0;
  int burst_left      = 0;
  int stuck_cycles    = 0;
  int rx_cycle        = 0;
  int rx_mode         = 0;

  // Clock generation.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Saturating per-channel RGB555 add or subtract, halved when active.
  function automatic logic [COLOR_W-1:0] rgb555_blend(input logic [COLOR_W-1:0] x,
                                                      input logic [COLOR_W-1:0] y);
    logic [31:0] a, b, sum, carry, diff, borrow, r;
    a = 32'(x);
    b = 32'(y);
    if (!cfg.math_control[MC_SUBTRACT]) begin
      sum = a + b;
      if (!half_on) begin
        carry = (sum - ((a ^ b) & MASK_LSB)) & MASK_MSB;
        r = (sum - carry) | (carry - (carry >> 5));
      end else begin
        r = (sum - ((a ^ b) & MASK_LSB)) >> 1;
      end
    end else begin
      diff = a - b + MASK_MSB;
      borrow = (diff - ((a ^ b) & MASK_MSB)) & MASK_MSB;
      r = (diff - borrow) & (borrow - (borrow >> 5));
      if (half_on) begin
        r = (r & MASK_HALVE) >> 1;
      end
    end
    return r[COLOR_W-1:0];
  endfunction

  // Pick the winning layer of one screen and its color; backdrop if none.
  function automatic void resolve_layer(input logic [PRI_W-1:0] pri,
                                        input logic [PAL_W-1:0] pal,
                                        input logic [TILE_W-1:0] tile,
                                        output logic [2:0] winner,
                                        output logic [COLOR_W-1:0] color);
    logic [PriorityBitsDefault-1:0] best, p;
    logic [31:0] pd, td;
    int k;
    best = '0;
    winner = LAYER_BACKDROP;
    color = pal_mem[0];
    for (k = 0; k < LAYERS; k++) begin
      p = pri[k*PriorityBitsDefault +: PriorityBitsDefault];
      // A strictly greater priority wins, so ties stay with the earlier layer.
      if (p > best) begin
        best = p;
        winner = 3'(k);
        color = pal_mem[pal[k*PAL_IDX_W +: PAL_IDX_W]];
      end
    end
    if (winner == LAYER_BG1 && cfg.math_control[MC_DIRECT] &&
        (cfg.bg_mode == MODE_3 || cfg.bg_mode == MODE_4 || cfg.bg_mode == MODE_7)) begin
      pd = 32'(pal[PAL_IDX_W-1:0]);
      td = 32'(tile);
      color = COLOR_W'(((pd << 7) & DIRECT_B_HI) + (td & DIRECT_B_LO) +
                       ((pd << 4) & DIRECT_G_HI) + ((td >> 5) & DIRECT_G_LO) +
                       ((pd << 2) & DIRECT_R_HI) + ((td >> 9) & DIRECT_R_LO));
    end
  endfunction

  // Advance the mirrored state by one beat; returns 1 when a pixel pair results.
  function automatic bit composite_pixel(input logic [1:0] op, input beat_fields_t f,
                                         output pixel_pair_t pair);
    logic               hires;
    logic [COLOR_W-1:0] s_res, m_res, col;
    logic [2:0]         lay;
    pair = '0;
    if (op == OP_LINE) begin
      m_col = pal_mem[0];
      s_col = m_col;
      m_math = !cfg.window_line_mask[WIN_MAIN];
      s_math = !cfg.window_line_mask[WIN_SUB] && cfg.layer_math_enable[LAYER_BACKDROP];
      s_clear = 1'b1;
      op_sub = 1'b0;
      half_on = cfg.math_control[MC_HALVE] && !cfg.math_control[MC_SUB_OPERAND] && m_math;
      return 1'b0;
    end
    if (op == OP_PALETTE) begin
      pal_mem[f.pal_addr] = f.pal_value;
      return 1'b0;
    end
    if (op != OP_PIXEL || f.line == '0) begin
      return 1'b0;
    end
    hires = cfg.display_control[DC_PSEUDO_HIRES] || cfg.bg_mode == MODE_5 ||
            cfg.bg_mode == MODE_6;
    s_res = '0;
    m_res = '0;
    // Blanked lines and display off give black without touching math state.
    if (!cfg.display_control[DC_DISPLAY_OFF] &&
        (cfg.display_control[DC_OVERSCAN] || f.line < BLANK_LINE)) begin
      // Sub screen first; it sees the math state left by the previous pixel or line start.
      resolve_layer(f.sub_pri, f.sub_pal, f.sub_tile, lay, col);
      s_col = col;
      s_clear = (lay == LAYER_BACKDROP);
      if (hires) begin
        if (!s_math) begin
          s_res = m_math ? s_col : '0;
        end else begin
          s_res = rgb555_blend(m_math ? s_col : '0, op_sub ? m_col : cfg.math_color);
        end
      end
      // Main screen, which also sets the math state for what follows.
      resolve_layer(f.main_pri, f.main_pal, f.main_tile, lay, col);
      m_col = col;
      s_math = cfg.layer_math_enable[lay] && f.win[WIN_SUB];
      if (lay == LAYER_SPRITE && f.main_pal[PAL_W-1 -: PAL_IDX_W] < SPRITE_MATH_MIN) begin
        s_math = 1'b0;
      end
      m_math = f.win[WIN_MAIN];
      if (!s_math) begin
        m_res = m_math ? m_col : '0;
      end else begin
        if (cfg.math_control[MC_SUB_OPERAND] && s_clear) begin
          op_sub = 1'b0;
          half_on = 1'b0;
        end else begin
          op_sub = cfg.math_control[MC_SUB_OPERAND];
          half_on = cfg.math_control[MC_HALVE] && m_math;
        end
        m_res = rgb555_blend(m_math ? m_col : '0, op_sub ? s_col : cfg.math_color);
      end
    end
    pair.first = {cfg.brightness, hires ? s_res : m_res};
    pair.second = {cfg.brightness, m_res};
    return 1'b1;
  endfunction

  // Send one beat with burst/gap idling, then record what it should produce.
  task automatic send_beat(input logic [1:0] op, input beat_fields_t f);
    int gap;
    pixel_pair_t pair;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - FIELDS_W){1'b0}}, f};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    beats_sent++;
    if (composite_pixel(op, f, pair)) begin
      pending_pixels.push_back(pair);
      pixels_expected++;
    end
  endtask

  // Stop sending and wait for every expected pixel pair; optionally settle.
  task automatic drain(input bit settle);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end
  endtask

  // Write all seven registers in index order; the block must be idle.
  task automatic set_config(input lpcm_cfg_t c);
    lpcm_reg_e idx;
    logic [CFG_DATA_W-1:0] val;
    idx = idx.first();
    repeat (7) begin
      case (idx)
        REG_MATH_CONTROL: val = CFG_DATA_W'(c.math_control);
        REG_LAYER_MATH:   val = CFG_DATA_W'(c.layer_math_enable);
        REG_MATH_COLOR:   val = CFG_DATA_W'(c.math_color);
        REG_BG_MODE:      val = CFG_DATA_W'(c.bg_mode);
        REG_DISPLAY_CTRL: val = CFG_DATA_W'(c.display_control);
        REG_BRIGHTNESS:   val = CFG_DATA_W'(c.brightness);
        default:          val = CFG_DATA_W'(c.window_line_mask);
      endcase
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= val;
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    cfg = c;
    config_count++;
  endtask

  // Five priorities in one of several styles: dense, sparse, tied or single.
  function automatic logic [PRI_W-1:0] rand_priorities();
    logic [PRI_W-1:0] v;
    int style, k;
    v = '0;
    style = $urandom_range(0, 3);
    for (k = 0; k < LAYERS; k++) begin
      case (style)
        0: v[k*4 +: 4] = 4'($urandom);
        1: v[k*4 +: 4] = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
        2: v[k*4 +: 4] = 4'($urandom_range(0, 2));
        default: v[k*4 +: 4] = '0;
      endcase
    end
    if (style == 3 && $urandom_range(0, 2) != 0) begin
      v[$urandom_range(0, LAYERS - 1)*4 +: 4] = 4'($urandom_range(1, 15));
    end
    return v;
  endfunction

  // Build a payload from explicit field values.
  function automatic beat_fields_t mk_fields(input logic [LINE_W-1:0] line,
                                             input logic [PRI_W-1:0] mpri,
                                             input logic [PAL_W-1:0] mpal,
                                             input logic [PRI_W-1:0] spri,
                                             input logic [PAL_W-1:0] spal,
                                             input logic [TILE_W-1:0] mtile,
                                             input logic [TILE_W-1:0] stile,
                                             input logic [1:0] win,
                                             input logic [PAL_AW-1:0] addr,
                                             input logic [COLOR_W-1:0] value);
    beat_fields_t f;
    f.line = line;
    f.main_pri = mpri;
    f.main_pal = mpal;
    f.sub_pri = spri;
    f.sub_pal = spal;
    f.main_tile = mtile;
    f.sub_tile = stile;
    f.win = win;
    f.pal_addr = addr;
    f.pal_value = value;
    return f;
  endfunction

  // Fill every palette entry so that no pixel ever reads an unwritten one.
  task automatic test_palette_load();
    int a;
    logic [COLOR_W-1:0] v;
    for (a = 0; a < PaletteEntries; a++) begin
      v = (a == 0) ? '0 : (a == PaletteEntries - 1) ? '1 : COLOR_W'($urandom);
      send_beat(OP_PALETTE, mk_fields('0, '0, '0, '0, '0, '0, '0, '0, PAL_AW'(a), v));
    end
    drain(1'b1);
  endtask

  // Hand-picked beats under a plain setting and an all-features setting.
  task automatic test_directed();
    lpcm_cfg_t c;
    int pass;
    for (pass = 0; pass < 2; pass++) begin
      if (pass == 0) begin
        c = '0;
        c.layer_math_enable = '1;
        c.math_color = '1;
      end else begin
        // Direct color in mode 7, pseudo hires, overscan, all math options.
        c = '1;
        c.layer_math_enable = '0;
        c.math_color = '0;
        c.display_control = 3'b101;
      end
      drain(1'b1);
      set_config(c);
      send_beat(OP_LINE, mk_fields('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
      // Everything transparent: backdrop on both screens.
      send_beat(OP_PIXEL, mk_fields(9'd1, '0, '0, '0, '0, '0, '0, 2'b11, '0, '0));
      // All priorities equal and maximal: bg1 takes the tie.
      send_beat(OP_PIXEL, mk_fields(9'd1, '1, '1, '1, '1, '1, '1, 2'b11, '0, '0));
      // Sprite wins with an index at the math threshold; sub bg2 wins.
      send_beat(OP_PIXEL, mk_fields(9'd100, 20'hF0000, 40'hC0_0000_0000, 20'h000F0,
                                    40'h00_0000_AB00, 16'h1C00, 16'h0400, 2'b11, '0, '0));
      // Sprite wins with an index just below the math threshold.
      send_beat(OP_PIXEL, mk_fields(9'd100, 20'hF0000, 40'hBF_0000_0000, '0, '0,
                                    '0, '0, 2'b11, '0, '0));
      // Line zero gives no result.
      send_beat(OP_PIXEL, mk_fields(9'd0, '1, '1, '1, '1, '1, '1, 2'b11, '0, '0));
      // Last visible line and first blanked line.
      send_beat(OP_PIXEL, mk_fields(9'd224, 20'h0000A, 40'h12, 20'h0A000,
                                    40'h34_0000_0000, 16'h1400, '0, 2'b10, '0, '0));
      send_beat(OP_PIXEL, mk_fields(9'd225, 20'h0000A, 40'h12, '0, '0, '0, '0,
                                    2'b11, '0, '0));
      send_beat(OP_PIXEL, mk_fields('1, '1, '1, '1, '1, '1, '1, 2'b11, '1, '1));
      // Unused opcode with every bit set is ignored.
      send_beat(OP_UNUSED, mk_fields(9'd1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
      // New backdrop color, then a line start that latches it.
      send_beat(OP_PALETTE, mk_fields('0, '0, '0, '0, '0, '0, '0, '0, '0,
                                      (pass == 0) ? 15'h7FFF : 15'h0000));
      send_beat(OP_LINE, mk_fields('1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
      // bg4 wins on main with only the main window enable set.
      send_beat(OP_PIXEL, mk_fields(9'd7, 20'h0F321, 40'h00_7766_5544, 20'h00100,
                                    40'h00_0099_0000, '0, '0, 2'b01, '0, '0));
    end
    drain(1'b1);
  endtask

  // Random phases, each with its own register setting, mostly pixel runs.
  task automatic test_random_phases();
    lpcm_cfg_t    c;
    beat_fields_t f;
    logic [1:0]   op;
    int phase, n, pick;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: c = '0;
        1: c = '1;
        2: begin
          c = '1;
          c.display_control = 3'b101;
        end
        default: begin
          c.math_control = 4'($urandom);
          c.layer_math_enable = 6'($urandom);
          c.math_color = COLOR_W'($urandom);
          c.bg_mode = 3'($urandom);
          c.display_control = 3'($urandom);
          // Keep the display on most of the time so the math is exercised.
          if ($urandom_range(0, 5) != 0) begin
            c.display_control[DC_DISPLAY_OFF] = 1'b0;
          end
          c.brightness = 4'($urandom);
          c.window_line_mask = 2'($urandom);
        end
      endcase
      drain(1'b1);
      set_config(c);
      for (n = 0; n < PHASE_BEATS; n++) begin
        // Once per few phases, hold the stream until the pipeline is empty.
        if (n == PHASE_BEATS / 2 && phase % 3 == 0) begin
          drain(1'b0);
        end
        f.line = LINE_W'($urandom);
        f.main_pri = rand_priorities();
        f.main_pal = {8'($urandom), 32'($urandom)};
        f.sub_pri = rand_priorities();
        f.sub_pal = {8'($urandom), 32'($urandom)};
        f.main_tile = TILE_W'($urandom);
        f.sub_tile = TILE_W'($urandom);
        f.win = 2'($urandom);
        f.pal_addr = PAL_AW'($urandom);
        f.pal_value = COLOR_W'($urandom);
        pick = $urandom_range(0, 99);
        if (n == 0 || pick < 7) begin
          op = OP_LINE;
        end else if (pick < 12) begin
          op = OP_PALETTE;
        end else if (pick < 14) begin
          op = OP_UNUSED;
        end else begin
          op = OP_PIXEL;
          // Mostly visible lines, with line zero and the blanked region mixed in.
          pick = $urandom_range(0, 19);
          if (pick == 0) begin
            f.line = '0;
          end else if (pick < 3) begin
            f.line = LINE_W'($urandom_range(224, 511));
          end else if (pick > 3) begin
            f.line = LINE_W'($urandom_range(1, 224));
          end
        end
        send_beat(op, f);
      end
    end
    drain(1'b1);
  endtask

  // Output stall pattern: switches between several randomly chosen styles.
  always @(posedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 128 == 0) begin
      rx_mode <= $urandom_range(0, 3);
    end
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_cycle % 5 != 2);
      default: m_axis_tready <= (rx_cycle % 16 > 10);
    endcase
  end

  // Compare each result beat with the oldest expected pixel pair.
  always @(posedge clk_i) begin
    pixel_pair_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = pixel_pair_t'(m_axis_tdata[2*PIXEL_W-1:0]);
      if (pending_pixels.size() == 0) begin
        $error("result beat with no pixel pair expected: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got.first !== want.first) begin
          $error("first_pixel mismatch: expected %h, actual %h", want.first, got.first);
          error_count++;
        end
        if (got.second !== want.second) begin
          $error("second_pixel mismatch: expected %h, actual %h", want.second, got.second);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", STUCK_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_palette_load();
    test_directed();
    test_random_phases();
    drain(1'b1);
    $display("Covered %0d beats over %0d register settings; %0d pixel pairs expected,",
             beats_sent, config_count, pixels_expected);
    $display("%0d checked, %0d pending, %0d errors.", pixels_checked,
             pending_pixels.size(), error_count);
    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
